>>> rtl/core/acc_pkg.sv
// Shared types and codes for the accumulator processor core.
package acc_pkg;

    localparam int WORD_W      = 32;
    localparam int CODE_W      = 8;
    localparam int CELL_ADDR_W = 10;
    localparam int CFG_IDX_W   = 2;

    localparam int DEF_MEM_WORDS    = 1024;
    localparam int DEF_OPERAND_BITS = 32;

    // item operations
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_EXEC    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // instruction opcodes (ASCII letters)
    localparam logic [CODE_W-1:0] OPC_ADD    = 8'h61; // a
    localparam logic [CODE_W-1:0] OPC_SUB    = 8'h73; // s
    localparam logic [CODE_W-1:0] OPC_NOP    = 8'h6e; // n
    localparam logic [CODE_W-1:0] OPC_JUMP   = 8'h6a; // j
    localparam logic [CODE_W-1:0] OPC_ZJUMP  = 8'h7a; // z
    localparam logic [CODE_W-1:0] OPC_WRITE  = 8'h77; // w
    localparam logic [CODE_W-1:0] OPC_READ   = 8'h72; // r
    localparam logic [CODE_W-1:0] OPC_INC    = 8'h69; // i
    localparam logic [CODE_W-1:0] OPC_HALT   = 8'h68; // h
    localparam logic [CODE_W-1:0] OPC_MEMADD = 8'h6d; // m

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_PC     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_ACC    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_STATUS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POWEROFF    = 2'd3;

    typedef struct packed {
        logic [1:0]               op;
        logic [CELL_ADDR_W-1:0]   cell_address;
        logic [CODE_W-1:0]        cell_opcode;
        logic signed [WORD_W-1:0] cell_first;
        logic signed [WORD_W-1:0] cell_second;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] pc_out;
        logic signed [WORD_W-1:0] acc_out;
        logic [WORD_W-1:0]        status_out;
        logic                     halted;
        logic [CODE_W-1:0]        executed_code;
    } t_out_item;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic              sub;
    } t_alu_req;

endpackage

>>> rtl/core/acc_mem.sv
// Single-port program/data memory with registered read data.
module acc_mem
    import acc_pkg::*;
#(
    parameter int WORDS = DEF_MEM_WORDS,
    parameter int WIDTH = CODE_W + 2 * DEF_OPERAND_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(WORDS)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [WORDS];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/acc_alu.sv
// Shared 32-bit add/subtract unit used for accumulator and pc updates.
module acc_alu
    import acc_pkg::*;
(
    input  t_alu_req          i_req,
    output logic [WORD_W-1:0] o_y
);

    assign o_y = i_req.sub ? (i_req.a - i_req.b) : (i_req.a + i_req.b);

endmodule

>>> rtl/core/accumulator_cpu_core.sv
// Accumulator processor core: sequencer, registers, memory and shared adder.
//
// Input channel (i_in_valid / o_in_stall / i_in_item) takes one item at a time:
// load a memory cell, execute one instruction, or restart the registers from
// the configuration registers. Every item gives exactly one result on the
// output channel (o_out_valid / i_out_stall / o_out_item).
// States per item, from acceptance until the result is registered:
//   load, restart, unused op, halted execute : FINISH
//   ADD, SUB, INC, NOP, JUMP, ZJUMP, WRITE    : EXEC, PCSTEP, FINISH
//   HALT                                      : EXEC, FINISH
//   READ, MEMADD                              : EXEC, DATA, PCSTEP, FINISH
// The single memory port (fetch, then data read or write) and the one
// shared adder (accumulator result, then pc) set these state sequences.
// A new item is taken while a finished result still waits in the output
// register; if the receiver stalls, the next result waits until the output
// register is taken and no further item is accepted meanwhile.
// Reset clears pc, accumulator and status word, sets the configuration
// registers to 0, 0, 0 and power-off word 1, and empties the output. Memory
// contents are undefined until written. MEM_WORDS is a power of two;
// addresses use the low index bits.
module accumulator_cpu_core
    import acc_pkg::*;
#(
    parameter int MEM_WORDS    = DEF_MEM_WORDS,
    parameter int OPERAND_BITS = DEF_OPERAND_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    localparam int ADDR_W = $clog2(MEM_WORDS);
    localparam int OPD    = OPERAND_BITS;
    localparam int CELL_W = CODE_W + 2 * OPD;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DATA,
        S_PCSTEP,
        S_FINISH
    } t_state;

    t_state                   r_state;
    logic [WORD_W-1:0]        r_pc;
    logic signed [OPD-1:0]    r_acc;
    logic [WORD_W-1:0]        r_status;
    logic [CELL_ADDR_W-1:0]   r_init_pc;
    logic [WORD_W-1:0]        r_init_acc;
    logic [WORD_W-1:0]        r_init_status;
    logic [WORD_W-1:0]        r_poweroff;
    logic [CELL_W-1:0]        r_ir;
    logic [CODE_W-1:0]        r_exec_code;
    logic                     r_out_valid;
    t_out_item                r_out_item;

    logic                     in_accept;
    logic                     halted;
    logic                     out_free;
    logic                     out_load;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_addr;
    logic [CELL_W-1:0]        mem_wdata;
    logic [CELL_W-1:0]        mem_rdata;
    logic [CODE_W-1:0]        rd_code;
    logic signed [OPD-1:0]    rd_first;
    logic signed [OPD-1:0]    rd_second;
    logic [CODE_W-1:0]        ir_code;
    logic signed [OPD-1:0]    ir_first;
    logic signed [OPD-1:0]    ir_second;
    logic signed [WORD_W-1:0] acc_ext;
    logic                     jump_taken;
    t_alu_req                 alu_req;
    logic [WORD_W-1:0]        alu_y;
    logic [WORD_W-1:0]        n_pc;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign halted     = (r_status == r_poweroff);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = (r_state == S_FINISH) && out_free;

    assign rd_code   = mem_rdata[CELL_W-1 -: CODE_W];
    assign rd_first  = mem_rdata[2*OPD-1 -: OPD];
    assign rd_second = mem_rdata[OPD-1:0];
    assign ir_code   = r_ir[CELL_W-1 -: CODE_W];
    assign ir_first  = r_ir[2*OPD-1 -: OPD];
    assign ir_second = r_ir[OPD-1:0];
    assign acc_ext   = WORD_W'(r_acc);

    assign jump_taken = (ir_code == OPC_JUMP) ||
                        ((ir_code == OPC_ZJUMP) && (r_acc == '0));

    // memory port: pc fetch while idle, load at accept, data access in EXEC
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_pc[ADDR_W-1:0];
        mem_wdata = {acc_ext[CODE_W-1:0], r_acc, r_acc};
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (i_in_item.op == OP_LOAD)) begin
                    mem_we    = 1'b1;
                    mem_addr  = ADDR_W'(WORD_W'(i_in_item.cell_address));
                    mem_wdata = {i_in_item.cell_opcode,
                                 i_in_item.cell_first[OPD-1:0],
                                 i_in_item.cell_second[OPD-1:0]};
                end
            end
            S_EXEC: begin
                mem_we   = (rd_code == OPC_WRITE);
                mem_addr = ADDR_W'(WORD_W'(rd_first));
            end
            S_DATA, S_PCSTEP, S_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // adder operands by step
    always_comb begin
        alu_req.a   = r_pc;
        alu_req.b   = WORD_W'(1);
        alu_req.sub = 1'b0;
        unique case (r_state)
            S_EXEC: begin
                alu_req.a   = WORD_W'(rd_first);
                alu_req.b   = WORD_W'(rd_second);
                alu_req.sub = (rd_code == OPC_SUB);
                if (rd_code == OPC_INC) begin
                    alu_req.a = acc_ext;
                    alu_req.b = WORD_W'(rd_first);
                end
            end
            S_DATA: begin
                alu_req.a = WORD_W'(rd_first);
                alu_req.b = (ir_code == OPC_MEMADD) ? WORD_W'(ir_second) : '0;
            end
            S_PCSTEP: begin
                alu_req.b = jump_taken ? WORD_W'(ir_first) : WORD_W'(1);
            end
            S_IDLE, S_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    assign n_pc = alu_y;

    acc_mem #(
        .WORDS (MEM_WORDS),
        .WIDTH (CELL_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    acc_alu u_alu (
        .i_req (alu_req),
        .o_y   (alu_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pc          <= '0;
            r_acc         <= '0;
            r_status      <= '0;
            r_init_pc     <= '0;
            r_init_acc    <= '0;
            r_init_status <= '0;
            r_poweroff    <= WORD_W'(1);
            r_exec_code   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_INIT_PC:     r_init_pc     <= i_cfg_data[CELL_ADDR_W-1:0];
                    CFG_INIT_ACC:    r_init_acc    <= i_cfg_data;
                    CFG_INIT_STATUS: r_init_status <= i_cfg_data;
                    CFG_POWEROFF:    r_poweroff    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_exec_code <= '0;
                        if (i_in_item.op == OP_RESTART) begin
                            r_pc     <= WORD_W'(r_init_pc);
                            r_acc    <= r_init_acc[OPD-1:0];
                            r_status <= r_init_status;
                            r_state  <= S_FINISH;
                        end else if ((i_in_item.op == OP_EXEC) && !halted) begin
                            r_state <= S_EXEC;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_EXEC: begin
                    r_ir        <= mem_rdata;
                    r_exec_code <= rd_code;
                    if ((rd_code == OPC_ADD) || (rd_code == OPC_SUB) ||
                        (rd_code == OPC_INC)) begin
                        r_acc <= alu_y[OPD-1:0];
                    end
                    if (rd_code == OPC_HALT) begin
                        r_status <= r_poweroff;
                        r_state  <= S_FINISH;
                    end else if ((rd_code == OPC_READ) || (rd_code == OPC_MEMADD)) begin
                        r_state <= S_DATA;
                    end else begin
                        r_state <= S_PCSTEP;
                    end
                end
                S_DATA: begin
                    r_acc   <= alu_y[OPD-1:0];
                    r_state <= S_PCSTEP;
                end
                S_PCSTEP: begin
                    r_pc    <= n_pc;
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    // hold the result until the output register is free
                    if (out_free) begin
                        r_out_item.pc_out        <= r_pc;
                        r_out_item.acc_out       <= acc_ext;
                        r_out_item.status_out    <= r_status;
                        r_out_item.halted        <= halted;
                        r_out_item.executed_code <= r_exec_code;
                        r_state                  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_mem_we_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == S_IDLE) && (i_in_item.op == OP_LOAD)) ||
                   ((r_state == S_EXEC) && (rd_code == OPC_WRITE)))
        else $error("memory written outside a load or WRITE step");

    a_exec_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> ($past(r_state) == S_IDLE))
        else $error("instruction step entered without an accepted item");

    a_pc_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_pc) |-> (($past(r_state) == S_PCSTEP) || ($past(r_state) == S_IDLE)))
        else $error("pc changed outside a pc step or restart");

    a_finish_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINISH) && out_free) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished item not placed in the output register");

    a_halt_sets_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && (rd_code == OPC_HALT)) |=> halted)
        else $error("HALT did not set the power-off status");

endmodule
